>>> hdl/fccw_pkg.sv
// Shared types and constants of the FAT12 cluster chain walker.
// Has no dependencies; every other file refers to it by scoped names.
package fccw_pkg;

  // Field widths
  localparam int CLUSTER_W  = 12;
  localparam int POS_W      = 13;
  localparam int BYTE_W     = 8;
  localparam int OFFS_W     = 32;
  localparam int BPC_W      = 16;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 32;

  // Input item kinds
  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_WALK = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_DATA_BASE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BPC       = 1'd1;

  // Configuration reset values
  localparam logic [OFFS_W-1:0] DATA_BASE_RST = 32'd16896;
  localparam logic [BPC_W-1:0]  BPC_RST       = 16'd512;

  // FAT12 entry codes
  localparam logic [CLUSTER_W-1:0] ENTRY_END = 12'hFF8;
  localparam logic [CLUSTER_W-1:0] ENTRY_BAD = 12'hFF7;
  localparam logic [CLUSTER_W-1:0] ENTRY_MIN = 12'h002;

  // Command queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = 1;
  localparam int QCNT_W  = 2;

  // One classified command
  typedef struct packed {
    logic                 walk;
    logic [POS_W-1:0]     addr;
    logic [BYTE_W-1:0]    data;
    logic [CLUSTER_W-1:0] start;
  } cmd_t;

endpackage

>>> hdl/fccw_front.sv
// Front end: accepts input transactions, classifies loads and walks.
// Drops loads beyond the table. Depends on fccw_pkg.
module fccw_front #(
  parameter int TABLE_BYTES = 8192
) (
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_kind,
  input  logic [fccw_pkg::POS_W-1:0]    in_byte_index,
  input  logic [fccw_pkg::BYTE_W-1:0]   in_byte_value,
  input  logic [fccw_pkg::CLUSTER_W-1:0] in_start_cluster,
  input  logic                          q_full,
  output logic                          q_push,
  output fccw_pkg::cmd_t                q_cmd
);

  localparam logic [fccw_pkg::POS_W:0] TB_LIM = (fccw_pkg::POS_W+1)'(TABLE_BYTES);

  logic is_walk;
  logic load_ok;

  // Classify: walks always go on, loads only when the byte is inside the table
  assign is_walk  = (in_kind == fccw_pkg::KIND_WALK);
  assign load_ok  = ({1'b0, in_byte_index} < TB_LIM);
  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full && (is_walk || load_ok);

  always_comb begin
    q_cmd.walk  = is_walk;
    q_cmd.addr  = in_byte_index;
    q_cmd.data  = in_byte_value;
    q_cmd.start = in_start_cluster;
  end

endmodule

>>> hdl/fccw_queue.sv
// Short command queue that decouples the front from the back end.
// Depends on fccw_pkg for the command type and depth.
module fccw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  fccw_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output fccw_pkg::cmd_t pop_cmd
);

  fccw_pkg::cmd_t                entry_r [fccw_pkg::QDEPTH];
  logic [fccw_pkg::QPTR_W-1:0]   wptr_r, rptr_r;
  logic [fccw_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign full      = (cnt_r == fccw_pkg::QCNT_W'(fccw_pkg::QDEPTH));
  assign not_empty = (cnt_r != '0);
  assign pop_cmd   = entry_r[rptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (push) wptr_r <= wptr_r + 1'b1;
      if (pop)  rptr_r <= rptr_r + 1'b1;
      cnt_r <= cnt_nxt;
    end
  end

  // Payload storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wptr_r] <= push_cmd;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> (cnt_r != fccw_pkg::QCNT_W'(fccw_pkg::QDEPTH)))
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (cnt_r != '0))
    else $error("queue pop while empty");

endmodule

>>> hdl/fccw_back.sv
// Back end: table memory, configuration registers, chain walk sequencer
// and the result register. Depends on fccw_pkg.
module fccw_back #(
  parameter int TABLE_BYTES = 8192,
  parameter int MAX_RUN     = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fccw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            q_valid,
  input  fccw_pkg::cmd_t                  q_cmd,
  output logic                            q_pop,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fccw_pkg::CLUSTER_W-1:0]  out_cluster,
  output logic [fccw_pkg::OFFS_W-1:0]     out_image_offset,
  output logic [fccw_pkg::CLUSTER_W-1:0]  out_next_entry,
  output logic                            out_last,
  output logic                            out_bad,
  output logic                            out_more
);

  localparam int AW     = $clog2(TABLE_BYTES);
  localparam int CNT_W  = $clog2(MAX_RUN + 1);
  localparam int PROD_W = fccw_pkg::CLUSTER_W + fccw_pkg::BPC_W + 2;
  localparam logic [fccw_pkg::POS_W:0] TB_LIM = (fccw_pkg::POS_W+1)'(TABLE_BYTES);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RUN - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_EV   = 2'd2;

  logic [1:0]                      state_r, state_nxt;
  logic [fccw_pkg::CLUSTER_W-1:0]  cur_r;
  logic [CNT_W-1:0]                cnt_r;
  logic [fccw_pkg::OFFS_W-1:0]     data_base_r;
  logic [fccw_pkg::BPC_W-1:0]      bpc_r;

  logic [fccw_pkg::BYTE_W-1:0]     mem [TABLE_BYTES];
  logic [fccw_pkg::BYTE_W-1:0]     rd0_r, rd1_r;
  logic                            ok0_r, ok1_r;
  logic [fccw_pkg::OFFS_W-1:0]     prod_r;

  logic [fccw_pkg::POS_W-1:0]      pos0, pos1;
  logic                            ok0, ok1;
  logic                            mem_we, rd_en;
  logic signed [fccw_pkg::CLUSTER_W:0] cm2;
  logic signed [fccw_pkg::BPC_W:0]     bpc_s;
  logic signed [PROD_W-1:0]            prod;

  logic [2*fccw_pkg::BYTE_W-1:0]   word;
  logic [fccw_pkg::CLUSTER_W-1:0]  entry;
  logic                            is_bad, is_end, is_limit, is_last;
  logic                            ev_go;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_base_r <= fccw_pkg::DATA_BASE_RST;
      bpc_r       <= fccw_pkg::BPC_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fccw_pkg::CFG_DATA_BASE: data_base_r <= cfg_data;
        fccw_pkg::CFG_BPC:       bpc_r       <= cfg_data[fccw_pkg::BPC_W-1:0];
        default:                 ;
      endcase
    end
  end

  // Entry position c*3/2 and its neighbor, with table bounds
  assign pos0 = {1'b0, cur_r} + {2'b00, cur_r[fccw_pkg::CLUSTER_W-1:1]};
  assign pos1 = pos0 + 1'b1;
  assign ok0  = ({1'b0, pos0} < TB_LIM);
  assign ok1  = ({1'b0, pos1} < TB_LIM);

  // (c - 2) * bytes_per_cluster, signed so small clusters wrap correctly
  assign cm2   = $signed({1'b0, cur_r}) - $signed(13'sd2);
  assign bpc_s = $signed({1'b0, bpc_r});
  assign prod  = PROD_W'(cm2) * PROD_W'(bpc_s);

  assign q_pop  = (state_r == S_IDLE) && q_valid;
  assign mem_we = q_pop && !q_cmd.walk;
  assign rd_en  = (state_r == S_RD);

  // Table memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[q_cmd.addr[AW-1:0]] <= q_cmd.data;
    end
    if (rd_en) begin
      rd0_r <= mem[pos0[AW-1:0]];
      rd1_r <= mem[pos1[AW-1:0]];
    end
  end

  // Read-side side data, registered alongside the memory data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      ok0_r  <= ok0;
      ok1_r  <= ok1;
      prod_r <= {{(fccw_pkg::OFFS_W-PROD_W){prod[PROD_W-1]}}, prod};
    end
  end

  // Entry decode and chain-end classification
  always_comb begin
    word     = {(ok1_r ? rd1_r : 8'h00), (ok0_r ? rd0_r : 8'h00)};
    entry    = cur_r[0] ? word[15:4] : word[11:0];
    is_bad   = (entry == fccw_pkg::ENTRY_BAD) || (entry < fccw_pkg::ENTRY_MIN);
    is_end   = is_bad || (entry >= fccw_pkg::ENTRY_END);
    is_limit = !is_end && (cnt_r == CNT_LAST);
    is_last  = is_end || is_limit;
  end

  assign ev_go = (state_r == S_EV) && (!out_valid || !out_stall);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE:  if (q_pop && q_cmd.walk) state_nxt = S_RD;
      S_RD:    state_nxt = S_EV;
      S_EV:    if (ev_go) state_nxt = is_last ? S_IDLE : S_RD;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Walk sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cur_r   <= '0;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (q_pop && q_cmd.walk) begin
        cur_r <= q_cmd.start;
        cnt_r <= '0;
      end else if (ev_go) begin
        cur_r <= entry;
        cnt_r <= cnt_r + 1'b1;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (ev_go) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ev_go) begin
      out_cluster      <= cur_r;
      out_image_offset <= data_base_r + prod_r;
      out_next_entry   <= entry;
      out_last         <= is_last;
      out_bad          <= is_bad;
      out_more         <= is_limit;
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != S_IDLE) |-> (cnt_r <= CNT_LAST))
    else $error("walk ran past the run limit");

  a_last_idles: assert property (@(posedge clk) disable iff (!rst_n)
    (ev_go && is_last) |=> (state_r == S_IDLE))
    else $error("walk continued after its final result");

  a_more_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_more) |-> (out_last && !out_bad))
    else $error("continuation result with bad or without last");

endmodule

>>> hdl/fat12_cluster_chain_walker.sv
// Top level of the FAT12 cluster chain walker: front, command queue, back.
// Depends on fccw_pkg, fccw_front, fccw_queue and fccw_back.
//
//   port group | direction | handshake          | carries
//   in_*       | in        | in_valid/in_stall   | load byte or walk start
//   out_*      | out       | out_valid/out_stall | one visited cluster
//   cfg_*      | in        | cfg_we              | data_base, bytes_per_cluster
//
// A load is written to the table when popped; a walk has a start step, then
// for each cluster visited a table read (two byte ports) and a decode step.
// The two-entry queue lets the input side keep accepting during a walk.
// Reset clears control state only; the table is not cleared.
// A stalled result holds the back end in its decode step until taken.
module fat12_cluster_chain_walker #(
  parameter int TABLE_BYTES = 8192,
  parameter int MAX_RUN     = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fccw_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fccw_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic                            in_kind,
  input  logic [fccw_pkg::POS_W-1:0]      in_byte_index,
  input  logic [fccw_pkg::BYTE_W-1:0]     in_byte_value,
  input  logic [fccw_pkg::CLUSTER_W-1:0]  in_start_cluster,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [fccw_pkg::CLUSTER_W-1:0]  out_cluster,
  output logic [fccw_pkg::OFFS_W-1:0]     out_image_offset,
  output logic [fccw_pkg::CLUSTER_W-1:0]  out_next_entry,
  output logic                            out_last,
  output logic                            out_bad,
  output logic                            out_more
);

  logic           q_full, q_push, q_pop, q_valid;
  fccw_pkg::cmd_t push_cmd, pop_cmd;

  fccw_front #(
    .TABLE_BYTES(TABLE_BYTES)
  ) u_front (
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_kind         (in_kind),
    .in_byte_index   (in_byte_index),
    .in_byte_value   (in_byte_value),
    .in_start_cluster(in_start_cluster),
    .q_full          (q_full),
    .q_push          (q_push),
    .q_cmd           (push_cmd)
  );

  fccw_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_valid),
    .pop_cmd  (pop_cmd)
  );

  fccw_back #(
    .TABLE_BYTES(TABLE_BYTES),
    .MAX_RUN    (MAX_RUN)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .q_valid         (q_valid),
    .q_cmd           (pop_cmd),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_cluster     (out_cluster),
    .out_image_offset(out_image_offset),
    .out_next_entry  (out_next_entry),
    .out_last        (out_last),
    .out_bad         (out_bad),
    .out_more        (out_more)
  );

endmodule

>>> dv/fat12_cluster_chain_walker_tb.sv
// Self-checking testbench for the FAT12 cluster chain walker: builds chains through
// table loads, walks them, and checks every visited cluster against a built-in predictor.
// Depends on fccw_pkg and fat12_cluster_chain_walker.
module fat12_cluster_chain_walker_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_BYTES    = 8192;
  localparam int MAX_RUN        = 64;
  localparam int SETTLE_CYCLES  = 16;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int LOAD_GOAL      = 470;

  // One visited cluster as the result channel reports it
  typedef struct packed {
    logic [fccw_pkg::CLUSTER_W-1:0] cluster;
    logic [fccw_pkg::OFFS_W-1:0]    image_offset;
    logic [fccw_pkg::CLUSTER_W-1:0] next_entry;
    logic                           last;
    logic                           bad;
    logic                           more;
  } visit_t;

  // DUT inputs, known from time zero
  logic                            clk;
  logic                            rst_n            = 1'b0;
  logic                            cfg_we           = 1'b0;
  logic [fccw_pkg::CFG_IDX_W-1:0]  cfg_index        = fccw_pkg::CFG_DATA_BASE;
  logic [fccw_pkg::CFG_DATA_W-1:0] cfg_data         = '0;
  logic                            in_valid         = 1'b0;
  logic                            in_kind          = fccw_pkg::KIND_LOAD;
  logic [fccw_pkg::POS_W-1:0]      in_byte_index    = '0;
  logic [fccw_pkg::BYTE_W-1:0]     in_byte_value    = '0;
  logic [fccw_pkg::CLUSTER_W-1:0]  in_start_cluster = '0;
  logic                            out_stall        = 1'b0;

  // DUT outputs
  logic                            in_stall;
  logic                            out_valid;
  logic [fccw_pkg::CLUSTER_W-1:0]  out_cluster;
  logic [fccw_pkg::OFFS_W-1:0]     out_image_offset;
  logic [fccw_pkg::CLUSTER_W-1:0]  out_next_entry;
  logic                            out_last;
  logic                            out_bad;
  logic                            out_more;

  // Predictor state: table shadow, register copies, walk state
  logic [fccw_pkg::BYTE_W-1:0]     fat_bytes [TABLE_BYTES];
  bit                              fat_written [TABLE_BYTES];
  logic [fccw_pkg::OFFS_W-1:0]     data_base_r = fccw_pkg::DATA_BASE_RST;
  logic [fccw_pkg::BPC_W-1:0]      bpc_r       = fccw_pkg::BPC_RST;
  logic [fccw_pkg::CLUSTER_W-1:0]  cur_cluster = '0;
  logic [6:0]                      run_len     = '0;

  visit_t                          pending_visits [$];
  logic [fccw_pkg::CLUSTER_W-1:0]  chain_heads [$];
  int                              mismatches  = 0;
  int                              items_sent  = 0;
  int                              idle_cycles = 0;
  bit                              idle_on     = 1'b1;

  fat12_cluster_chain_walker #(
    .TABLE_BYTES(TABLE_BYTES),
    .MAX_RUN(MAX_RUN)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_kind(in_kind),
    .in_byte_index(in_byte_index),
    .in_byte_value(in_byte_value),
    .in_start_cluster(in_start_cluster),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_cluster(out_cluster),
    .out_image_offset(out_image_offset),
    .out_next_entry(out_next_entry),
    .out_last(out_last),
    .out_bad(out_bad),
    .out_more(out_more)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Follow the chain from start. Returns 0 if any table byte on the way was never
  // written. With commit set, queues the expected visits and updates walk state.
  function automatic bit trace_chain(input logic [fccw_pkg::CLUSTER_W-1:0] start,
                                     input bit commit);
    logic [fccw_pkg::CLUSTER_W-1:0] c;
    logic [fccw_pkg::CLUSTER_W-1:0] nxt;
    int                             pos;
    bit                             bad;
    bit                             done;
    bit                             lim;
    visit_t                         v;
    c = start;
    for (int n = 0; n < MAX_RUN; n++) begin
      pos = (int'(c) * 3) / 2;
      if (!fat_written[pos] || !fat_written[pos + 1]) return 1'b0;
      // odd clusters sit in the upper 12 bits of the little-endian word
      nxt = c[0] ? {fat_bytes[pos + 1], fat_bytes[pos][7:4]}
                 : {fat_bytes[pos + 1][3:0], fat_bytes[pos]};
      bad  = (nxt == fccw_pkg::ENTRY_BAD) || (nxt < fccw_pkg::ENTRY_MIN);
      done = bad || (nxt >= fccw_pkg::ENTRY_END);
      lim  = !done && (n == MAX_RUN - 1);
      if (commit) begin
        v.cluster      = c;
        v.image_offset = data_base_r + (32'(c) - 32'd2) * 32'(bpc_r);
        v.next_entry   = nxt;
        v.last         = done || lim;
        v.bad          = bad;
        v.more         = lim;
        pending_visits.insert(pending_visits.size(), v);
        cur_cluster = nxt;
        run_len     = 7'(n + 1);
      end
      if (done || lim) break;
      c = nxt;
    end
    return 1'b1;
  endfunction

  function automatic string visit_text(input visit_t v);
    return $sformatf("cluster=%03h offset=%08h next=%03h last=%0b bad=%0b more=%0b",
                     v.cluster, v.image_offset, v.next_entry, v.last, v.bad, v.more);
  endfunction

  function automatic void flag_mismatch(input string why);
    mismatches++;
    if (mismatches <= 10) $display("[%0t] mismatch: %s", $time, why);
  endfunction

  // Send one transaction; random gap first, predictor updated on acceptance
  task automatic send_item(input logic kind,
                           input logic [fccw_pkg::POS_W-1:0] idx,
                           input logic [fccw_pkg::BYTE_W-1:0] val,
                           input logic [fccw_pkg::CLUSTER_W-1:0] start);
    int gap;
    gap = (idle_on && $urandom_range(0, 5) == 0) ? $urandom_range(1, 12) : 0;
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_kind          <= kind;
    in_byte_index    <= idx;
    in_byte_value    <= val;
    in_start_cluster <= start;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    items_sent++;
    if (kind == fccw_pkg::KIND_LOAD) begin
      fat_bytes[idx]   = val;
      fat_written[idx] = 1'b1;
    end else begin
      void'(trace_chain(start, 1'b1));
    end
  endtask

  task automatic load_byte(input logic [fccw_pkg::POS_W-1:0] idx,
                           input logic [fccw_pkg::BYTE_W-1:0] val);
    send_item(fccw_pkg::KIND_LOAD, idx, val, fccw_pkg::CLUSTER_W'($urandom));
  endtask

  task automatic walk_from(input logic [fccw_pkg::CLUSTER_W-1:0] start);
    send_item(fccw_pkg::KIND_WALK, fccw_pkg::POS_W'($urandom),
              fccw_pkg::BYTE_W'($urandom), start);
  endtask

  // Write the 12-bit entry of cluster c, keeping the neighbor's nibble intact
  task automatic set_entry(input logic [fccw_pkg::CLUSTER_W-1:0] c,
                           input logic [fccw_pkg::CLUSTER_W-1:0] val);
    int                          pos;
    logic [fccw_pkg::BYTE_W-1:0] lo;
    logic [fccw_pkg::BYTE_W-1:0] hi;
    pos = (int'(c) * 3) / 2;
    lo  = fat_written[pos] ? fat_bytes[pos] : fccw_pkg::BYTE_W'($urandom);
    hi  = fat_written[pos + 1] ? fat_bytes[pos + 1] : fccw_pkg::BYTE_W'($urandom);
    if (c[0]) begin
      lo[7:4] = val[3:0];
      hi      = val[11:4];
    end else begin
      lo      = val[7:0];
      hi[3:0] = val[11:8];
    end
    load_byte(fccw_pkg::POS_W'(pos), lo);
    load_byte(fccw_pkg::POS_W'(pos + 1), hi);
  endtask

  // Stop sending and let every expected visit arrive, plus any load still in flight
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_visits.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cfg(input logic [fccw_pkg::CFG_IDX_W-1:0] idx,
                           input logic [fccw_pkg::CFG_DATA_W-1:0] val);
    drain();
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == fccw_pkg::CFG_DATA_BASE) data_base_r = val;
    else bpc_r = val[fccw_pkg::BPC_W-1:0];
  endtask

  // Build a short random chain with a random ending, then walk it
  task automatic random_chain();
    logic [fccw_pkg::CLUSTER_W-1:0] members [$];
    logic [fccw_pkg::CLUSTER_W-1:0] term;
    int                             len;
    len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
    repeat (len) begin
      members.insert(members.size(),
                     ($urandom_range(0, 3) == 0) ? fccw_pkg::CLUSTER_W'($urandom_range(0, 63))
                                                 : fccw_pkg::CLUSTER_W'($urandom));
    end
    case ($urandom_range(0, 5))
      0:       term = members[$urandom_range(0, len - 1)];  // loop back into the chain
      1:       term = fccw_pkg::ENTRY_BAD;
      2:       term = fccw_pkg::CLUSTER_W'($urandom_range(0, 1));
      default: term = fccw_pkg::CLUSTER_W'($urandom_range(fccw_pkg::ENTRY_END, 12'hFFF));
    endcase
    for (int i = 0; i < len; i++) set_entry(members[i], (i == len - 1) ? term : members[i + 1]);
    walk_from(members[0]);
    chain_heads.insert(chain_heads.size(), members[0]);
    if (chain_heads.size() > 64) void'(chain_heads.pop_front());
  endtask

  // Mixed traffic: mostly fresh chains, some re-walks, table noise, rare full pauses
  task automatic run_traffic(input int count);
    int                             goal;
    logic [fccw_pkg::CLUSTER_W-1:0] head;
    goal = items_sent + count;
    while (items_sent < goal) begin
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: random_chain();
        12, 13, 14, 15: begin
          if (chain_heads.size() != 0) begin
            head = chain_heads[$urandom_range(0, chain_heads.size() - 1)];
            // noise may have broken the chain into unwritten bytes
            if (trace_chain(head, 1'b0)) walk_from(head);
            else load_byte(fccw_pkg::POS_W'($urandom), fccw_pkg::BYTE_W'($urandom));
          end else begin
            load_byte(fccw_pkg::POS_W'($urandom), fccw_pkg::BYTE_W'($urandom));
          end
        end
        19:      drain();
        default: load_byte(fccw_pkg::POS_W'($urandom), fccw_pkg::BYTE_W'($urandom));
      endcase
    end
  endtask

  // End-of-chain markers and a plain multi-cluster chain
  task automatic test_chain_end();
    set_entry(12'h000, fccw_pkg::ENTRY_END);
    walk_from(12'h000);
    set_entry(12'h002, 12'h003);
    set_entry(12'h003, 12'h004);
    set_entry(12'h004, 12'hFFF);
    walk_from(12'h002);
  endtask

  // Bad entries (0, 1, 0xFF7) reached from unusual start clusters
  task automatic test_bad_entries();
    set_entry(12'h001, 12'h000);
    walk_from(12'h001);
    set_entry(12'hFFF, 12'h001);
    walk_from(12'hFFF);
    set_entry(12'hFF7, fccw_pkg::ENTRY_BAD);
    walk_from(12'hFF7);
  endtask

  // A self-referencing cluster is cut off by the run limit
  task automatic test_run_limit();
    set_entry(12'h005, 12'h005);
    walk_from(12'h005);
    load_byte(13'h1FFF, 8'hFF);
  endtask

  // Register extremes, a random setting, then back to reset values
  task automatic test_config_sweep();
    for (int k = 0; k < 4; k++) begin
      case (k)
        0: begin
          write_cfg(fccw_pkg::CFG_DATA_BASE, 32'd0);
          write_cfg(fccw_pkg::CFG_BPC, 32'd1);
        end
        1: begin
          write_cfg(fccw_pkg::CFG_DATA_BASE, 32'hFFFF_FFFF);
          write_cfg(fccw_pkg::CFG_BPC, 32'd32768);
        end
        2: begin
          write_cfg(fccw_pkg::CFG_DATA_BASE, $urandom);
          write_cfg(fccw_pkg::CFG_BPC, $urandom_range(1, 32768));
        end
        default: begin
          write_cfg(fccw_pkg::CFG_DATA_BASE, fccw_pkg::DATA_BASE_RST);
          write_cfg(fccw_pkg::CFG_BPC, 32'(fccw_pkg::BPC_RST));
        end
      endcase
      run_traffic(35);
    end
  endtask

  task automatic test_random_mix();
    run_traffic(400 - items_sent);
  endtask

  // Last stretch with no idling on either side
  task automatic test_full_rate();
    drain();
    idle_on = 1'b0;
    run_traffic(LOAD_GOAL - items_sent);
  endtask

  // Result stall: random bursts with calm stretches in between
  int stall_left = 0;
  int calm_left  = 0;
  always @(negedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left--;
    end else if (calm_left > 0) begin
      out_stall <= 1'b0;
      calm_left--;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_left = $urandom_range(1, 12) - 1;
      if ($urandom_range(0, 3) == 0) calm_left = $urandom_range(20, 60);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Result checker
  always @(posedge clk) begin
    visit_t got;
    visit_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_cluster, out_image_offset, out_next_entry, out_last, out_bad, out_more};
      if (pending_visits.size() == 0) begin
        flag_mismatch({"unexpected ", visit_text(got)});
      end else begin
        want = pending_visits.pop_front();
        if (got !== want)
          flag_mismatch({"expected ", visit_text(want), " got ", visit_text(got)});
      end
    end
  end

  // Watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_chain_end();
    test_bad_entries();
    test_run_limit();
    test_config_sweep();
    test_random_mix();
    test_full_rate();
    drain();
    if (mismatches == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
